// ===== design/tdf_pkg.sv =====
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared types and constants for the trial division factorizer.
// ----------------------------------------------------------------------------
package tdf_pkg;

   localparam int WIDTH_DEFAULT = 32;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_ONE  = 2'd1,
      STATUS_ZERO = 2'd2
   } status_type;

   // source of the factor field for an emitted result
   typedef enum logic [1:0] {
      EMIT_NONE      = 2'd0,
      EMIT_DIVISOR   = 2'd1,
      EMIT_REMAINDER = 2'd2
   } emit_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_SPECIAL,
      ST_TEST,
      ST_DIVIDE,
      ST_EMIT,
      ST_FINAL
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic         load;
      logic         div_start;
      logic         take_quot;
      logic         next_div;
      logic         emit;
      emit_sel_type emit_sel;
      logic         emit_last;
      status_type   emit_status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_zero;
      logic is_one;
      logic loop_go;
      logic rem_one;
      logic div_done;
      logic div_even;
      logic quot_one;
      logic out_free;
   } stat_type;

endpackage

// ===== design/tdf_divider.sv =====
// ----------------------------------------------------------------------------
// tdf_divider
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdf_divider import tdf_pkg::*; #(
   parameter int WIDTH = WIDTH_DEFAULT,
   parameter int DIV_W = (WIDTH_DEFAULT + 1) / 2 + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,   // held stable by the caller while busy
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [DIV_W-1:0] remainder
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] quot_ff, quot_in;
   logic [DIV_W-1:0] rem_ff, rem_in;

   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;
   logic             fits;

   assign trial = {rem_ff, quot_ff[WIDTH-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = CNT_W'(WIDTH);
         quot_in = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         // remainder stays below divisor, so diff fits DIV_W bits
         rem_in  = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quot_in = {quot_ff[WIDTH-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

// ===== design/tdf_datapath.sv =====
// ----------------------------------------------------------------------------
// tdf_datapath
// Number, remainder, trial divisor and its square, divider and result register.
// ----------------------------------------------------------------------------
module tdf_datapath import tdf_pkg::*; #(
   parameter int WIDTH = WIDTH_DEFAULT,
   parameter int DIV_W = (WIDTH_DEFAULT + 1) / 2 + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output stat_type         stat,
   input  logic [WIDTH-1:0] number,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic [WIDTH-1:0] rsp_factor,
   output logic             rsp_last,
   output status_type       rsp_status
);

   localparam int SQ_W = WIDTH + 2;

   logic [WIDTH-1:0] orig_ff, orig_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] div_ff, div_in;
   logic [SQ_W-1:0]  sq_ff, sq_in;      // div_ff squared, kept incrementally

   logic             valid_ff, valid_in;
   logic [WIDTH-1:0] factor_ff, factor_in;
   logic             last_ff, last_in;
   status_type       status_ff, status_in;

   logic             div_done;
   logic [WIDTH-1:0] quotient;
   logic [DIV_W-1:0] div_rem;

   tdf_divider #(
      .WIDTH (WIDTH),
      .DIV_W (DIV_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (rem_ff),
      .divisor   (div_ff),
      .done      (div_done),
      .quotient  (quotient),
      .remainder (div_rem)
   );

   always_comb begin
      orig_in = orig_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      sq_in   = sq_ff;
      if (cmd.load) begin
         orig_in = number;
         rem_in  = number;
         div_in  = DIV_W'(2);
         sq_in   = SQ_W'(4);
      end
      if (cmd.take_quot) begin
         rem_in = quotient;
      end
      if (cmd.next_div) begin
         if (div_ff == DIV_W'(2)) begin
            div_in = DIV_W'(3);
            sq_in  = SQ_W'(9);
         end else begin
            // (d+2)^2 = d^2 + 4d + 4
            div_in = div_ff + DIV_W'(2);
            sq_in  = sq_ff + SQ_W'({div_ff, 2'b00}) + SQ_W'(4);
         end
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      factor_in = factor_ff;
      last_in   = last_ff;
      status_in = status_ff;
      if (cmd.emit) begin
         valid_in  = 1'b1;
         last_in   = cmd.emit_last;
         status_in = cmd.emit_status;
         case (cmd.emit_sel)
            EMIT_DIVISOR:   factor_in = WIDTH'(div_ff);
            EMIT_REMAINDER: factor_in = rem_ff;
            default:        factor_in = '0;
         endcase
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      orig_ff   <= orig_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      sq_ff     <= sq_in;
      factor_ff <= factor_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   always_comb begin
      stat.is_zero  = orig_ff == '0;
      stat.is_one   = orig_ff == WIDTH'(1);
      stat.rem_one  = rem_ff == WIDTH'(1);
      stat.loop_go  = (sq_ff <= SQ_W'(orig_ff)) && (rem_ff != WIDTH'(1));
      stat.div_done = div_done;
      stat.div_even = div_rem == '0;
      stat.quot_one = quotient == WIDTH'(1);
      stat.out_free = !valid_ff || rsp_ready;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_factor = factor_ff;
   assign rsp_last   = last_ff;
   assign rsp_status = status_ff;

endmodule

// ===== design/tdf_controller.sv =====
// ----------------------------------------------------------------------------
// tdf_controller
// Sequencer for the trial division loop.
// ----------------------------------------------------------------------------
module tdf_controller import tdf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_CLASSIFY;
         ST_CLASSIFY: begin
            if (stat.is_zero || stat.is_one) state_in = ST_SPECIAL;
            else                             state_in = ST_TEST;
         end
         ST_SPECIAL:  if (stat.out_free) state_in = ST_IDLE;
         ST_TEST: begin
            if (stat.loop_go)      state_in = ST_DIVIDE;
            else if (stat.rem_one) state_in = ST_IDLE;
            else                   state_in = ST_FINAL;
         end
         ST_DIVIDE: begin
            if (stat.div_done) begin
               if (stat.div_even) state_in = ST_EMIT;
               else               state_in = ST_TEST;
            end
         end
         ST_EMIT:     if (stat.out_free) state_in = ST_TEST;
         ST_FINAL:    if (stat.out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd             = '0;
      cmd.emit_sel    = EMIT_NONE;
      cmd.emit_status = STATUS_OK;
      req_ready       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SPECIAL: begin
            cmd.emit        = stat.out_free;
            cmd.emit_last   = 1'b1;
            cmd.emit_status = stat.is_zero ? STATUS_ZERO : STATUS_ONE;
         end
         ST_TEST: begin
            cmd.div_start = stat.loop_go;
         end
         ST_DIVIDE: begin
            cmd.next_div = stat.div_done && !stat.div_even;
         end
         ST_EMIT: begin
            // a quotient of one leaves nothing more to factor
            cmd.emit      = stat.out_free;
            cmd.take_quot = stat.out_free;
            cmd.emit_sel  = EMIT_DIVISOR;
            cmd.emit_last = stat.quot_one;
         end
         ST_FINAL: begin
            cmd.emit      = stat.out_free;
            cmd.emit_sel  = EMIT_REMAINDER;
            cmd.emit_last = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/trial_division_factorizer.sv =====
// ----------------------------------------------------------------------------
// trial_division_factorizer
// Prime factorization by trial division: factors out ascending, by multiplicity.
// ----------------------------------------------------------------------------
// Flow: inputs 0 and 1 are classified, then answered from a special state.
// Each trial divisor takes a test step, WIDTH restoring divide steps in the
// shared divider and a step to act on the result; a hit adds an emit step,
// held while the response side stalls, and retries the divisor.
// Throughput: one number at a time, paced by the one-bit-per-cycle divider.
// Reset: synchronous, active high; returns to idle and drops rsp_tvalid.
// ----------------------------------------------------------------------------
module trial_division_factorizer import tdf_pkg::*; #(
   parameter int WIDTH = WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = number[WIDTH-1:0], zero padded to whole bytes
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   // response: tdata = factor[WIDTH-1:0], zero padded to whole bytes
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [((WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic                              rsp_tlast,
   // tuser = status[1:0]: ok, input one, input zero
   output logic [1:0]                        rsp_tuser
);

   localparam int TDATA_W = ((WIDTH + 7) / 8) * 8;
   // trial divisor never passes sqrt(2^WIDTH) + 2
   localparam int DIV_W   = (WIDTH + 1) / 2 + 1;

   cmd_type          cmd;
   stat_type         stat;
   logic [WIDTH-1:0] rsp_factor;
   status_type       rsp_status;

   // FSM: one transaction in flight; loops test -> divide -> (emit) per divisor
   tdf_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath owns the operand registers, divider and the output register, so
   // a new request is taken while the final result still waits downstream.
   tdf_datapath #(
      .WIDTH (WIDTH),
      .DIV_W (DIV_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .number     (req_tdata[WIDTH-1:0]),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_factor (rsp_factor),
      .rsp_last   (rsp_tlast),
      .rsp_status (rsp_status)
   );

   assign rsp_tdata = TDATA_W'(rsp_factor);
   assign rsp_tuser = rsp_status;

endmodule

// ===== bench/factor_checker.sv =====
// ----------------------------------------------------------------------------
// factor_checker
// Watches both streams of the factorizer, predicts the factor list of every
// accepted number and compares each response transaction against it.
// ----------------------------------------------------------------------------
module factor_checker import tdf_pkg::*; #(
   parameter int WIDTH = WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [((WIDTH + 7) / 8) * 8 - 1:0] req_tdata,  // number
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [((WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,  // factor
   input  logic                               rsp_tlast,
   input  logic [1:0]                         rsp_tuser,  // status
   output int unsigned                        pending_count,
   output int unsigned                        error_count
);

   typedef struct {
      logic [WIDTH-1:0] factor;
      logic             last;
      status_type       status;
   } factor_result_type;

   factor_result_type expected_factors[$];
   int unsigned       results_seen;

   initial begin
      error_count   = 0;
      pending_count = 0;
      results_seen  = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
      error_count++;
   endtask

   function automatic void add_expected(input factor_result_type item);
      expected_factors = {expected_factors, item};
   endfunction

   // Trial division: 2, then odd divisors, until divisor squared exceeds the
   // number. One result is held back so the final one can carry the last mark.
   function automatic void predict_factors(input logic [WIDTH-1:0] number);
      longint unsigned   value;
      longint unsigned   rest;
      longint unsigned   divisor;
      factor_result_type held;
      bit                have_held;
      value       = number;
      rest        = value;
      divisor     = 2;
      have_held   = 1'b0;
      held.factor = '0;
      held.last   = 1'b1;
      held.status = STATUS_OK;
      if (value < 2) begin
         held.status = (value == 0) ? STATUS_ZERO : STATUS_ONE;
         add_expected(held);
         return;
      end
      while (divisor <= value / divisor) begin
         while (rest % divisor == 0) begin
            if (have_held)
               add_expected(held);
            held.factor = divisor[WIDTH-1:0];
            held.last   = 1'b0;
            have_held   = 1'b1;
            rest        = rest / divisor;
         end
         divisor = (divisor == 2) ? 3 : divisor + 2;
      end
      if (rest != 1) begin
         if (have_held)
            add_expected(held);
         held.factor = rest[WIDTH-1:0];
         have_held   = 1'b1;
      end
      held.last = 1'b1;
      add_expected(held);
   endfunction

   task automatic check_result(input logic [WIDTH-1:0] factor, input logic last,
                               input logic [1:0] status);
      factor_result_type want;
      if (expected_factors.size() == 0) begin
         report_mismatch($sformatf("unexpected factor %0d status %0d", factor, status));
         return;
      end
      want = expected_factors.pop_front();
      if (factor !== want.factor)
         report_mismatch($sformatf("factor %0d, want %0d", factor, want.factor));
      if (last !== want.last)
         report_mismatch($sformatf("last %b, want %b", last, want.last));
      if (status !== want.status)
         report_mismatch($sformatf("status %0d, want %0d", status, want.status));
      results_seen++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid === 1'b1 && req_tready === 1'b1)
            predict_factors(req_tdata[WIDTH-1:0]);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
            check_result(rsp_tdata[WIDTH-1:0], rsp_tlast, rsp_tuser);
      end
      pending_count <= expected_factors.size();
   end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Feeds numbers to the trial division factorizer: a directed set (zero, one,
// primes, prime powers, worst-case width) then random numbers kept small so
// that the one-bit-per-cycle divider stays fast. Both stream sides idle at
// random; the checker predicts and compares every factor transaction.
// ----------------------------------------------------------------------------
module testbench;
   import tdf_pkg::*;

   localparam int WIDTH  = WIDTH_DEFAULT;
   localparam int BUS_W  = ((WIDTH + 7) / 8) * 8;
   localparam int NUM_RANDOM = 80;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [BUS_W-1:0] req_tdata  = '0;     // number
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [BUS_W-1:0] rsp_tdata;           // factor
   logic             rsp_tlast;
   logic [1:0]       rsp_tuser;           // status
   int unsigned      pending_count;
   int unsigned      error_count;
   bit               steady = 1'b0;       // no idling on either side while set

   always #2 clock = ~clock;

   trial_division_factorizer #(.WIDTH(WIDTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   factor_checker #(.WIDTH(WIDTH)) checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .pending_count (pending_count),
      .error_count   (error_count)
   );

   // One request transaction: optional gap with tvalid low, then hold until taken.
   // tvalid gets a single nonblocking write per step, so back-to-back stays high.
   task automatic send_number(input logic [WIDTH-1:0] number);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= number;
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   // Cost grows with the square root of the number, so random numbers stay
   // mostly below 2^18; products of small factors give repeated factors.
   function automatic logic [WIDTH-1:0] draw_number();
      int unsigned      pick;
      int unsigned      bits;
      int unsigned      mult;
      logic [WIDTH-1:0] value;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         return $urandom_range(0, 1);
      if (pick < 8) begin
         value = 1;
         repeat (20) begin
            mult = $urandom_range(2, 13);
            if (value * mult < (1 << 18))
               value = value * mult;
         end
         return value;
      end
      bits  = (pick < 18) ? $urandom_range(2, 16) : $urandom_range(17, 22);
      value = $urandom & ((1 << bits) - 1);
      return value | (1 << (bits - 1));
   endfunction

   // response side: random stall before every factor, none in steady phases
   initial begin : rsp_side
      int unsigned stall;
      @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 6);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   initial begin : req_side
      int i;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // special inputs, small primes and prime powers
      send_number(0);          send_number(1);          send_number(2);
      send_number(3);          send_number(4);          send_number(5);
      send_number(6);          send_number(9);          send_number(25);
      send_number(30);         send_number(49);         send_number(97);
      send_number(1024);       send_number(63001);      send_number(65537);
      // large primes, a product of two close primes, a long run of twos
      send_number(999983);     send_number(16744463);   send_number(16777213);
      send_number(16777215);   send_number(1 << 24);
      // every input bit high: full-width worst case, then back to the small cases
      send_number('1);
      send_number(1);          send_number(0);

      for (i = 0; i < NUM_RANDOM; i++) begin
         if (i % 20 == 0)
            steady = ($urandom_range(0, 2) == 0);
         send_number(draw_number());
      end
      req_tvalid <= 1'b0;

      // drain: pending count is registered, so look after the next edge
      do @(posedge clock); while (pending_count != 0);
      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("[trial_division_factorizer] OK");
      else
         $display("[trial_division_factorizer] ERROR");
      $finish;
   end

   // The watchdog allows about six times the slowest correct run (the full-width
   // number plus every random number at its largest size).
   initial begin : watchdog
      #100_000_000;
      $display("[trial_division_factorizer] ERROR");
      $finish;
   end

endmodule

// ===== trial_division_factorizer.f =====
design/tdf_pkg.sv
design/tdf_divider.sv
design/tdf_datapath.sv
design/tdf_controller.sv
design/trial_division_factorizer.sv
bench/factor_checker.sv
bench/testbench.sv
